>>> sv/tsff_pkg.sv
// ============================================================================
// Tire slip friction force package
// Shared constants, register index codes and the arctangent table for the
// tire slip and friction-limited force pipeline.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tsff_pkg;

    // Default word layout of all Q values.
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Angle accumulator of the CORDIC unit works in Q24.
    localparam int ANG_FRAC     = 24;
    localparam int ANG_BITS     = 27;
    localparam int CORDIC_STEPS = 25;

    // Width of the configuration index; codes above the list are ignored.
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GRIP  = 3'd0,
        CFG_LONG  = 3'd1,
        CFG_LAT   = 3'd2,
        CFG_BRAKE = 3'd3
    } cfg_index_t;

    // atan(2^-i) in Q24.
    function automatic logic [ANG_BITS-1:0] atan_q24(input int unsigned idx);
        logic [ANG_BITS-1:0] v;
        case (idx)
            0:       v = 27'd13176795;
            1:       v = 27'd7778716;
            2:       v = 27'd4110060;
            3:       v = 27'd2086331;
            4:       v = 27'd1047214;
            5:       v = 27'd524117;
            6:       v = 27'd262123;
            7:       v = 27'd131069;
            8:       v = 27'd65536;
            9:       v = 27'd32768;
            10:      v = 27'd16384;
            11:      v = 27'd8192;
            12:      v = 27'd4096;
            13:      v = 27'd2048;
            14:      v = 27'd1024;
            15:      v = 27'd512;
            16:      v = 27'd256;
            17:      v = 27'd128;
            18:      v = 27'd64;
            19:      v = 27'd32;
            20:      v = 27'd16;
            21:      v = 27'd8;
            22:      v = 27'd4;
            23:      v = 27'd2;
            24:      v = 27'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/tire_slip_friction_force.sv
// ============================================================================
// Tire slip friction force
// Linear tire model with a friction circle, one word in and one word out.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds only while the output register is full and not taken.
// Reset: asynchronous, active low; clears all valid bits and loads the
// configuration registers with their default values. No clearing pass.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tire_slip_friction_force
    import tsff_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [WORD_BITS-2:0]          cfg_data,

    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic signed [WORD_BITS-1:0]   wheel_speed,
    input  wire logic signed [WORD_BITS-1:0]   vehicle_speed,
    input  wire logic signed [WORD_BITS-1:0]   lateral_velocity,
    input  wire logic signed [WORD_BITS-1:0]   normal_load,
    input  wire logic signed [WORD_BITS-1:0]   brake_torque,
    input  wire logic [WORD_BITS-2:0]          surface_grip,
    input  wire logic signed [WORD_BITS-1:0]   steer_angle,

    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic signed [FRAC_BITS+1:0]   slip_ratio,
    output      logic signed [FRAC_BITS+1:0]   slip_angle,
    output      logic signed [WORD_BITS-1:0]   long_force,
    output      logic signed [WORD_BITS-1:0]   lat_force,
    output      logic [WORD_BITS-2:0]          grip_used,
    output      logic                          slipping,
    output      logic                          locked
);

    // ------------------------------------------------------------------------
    // Widths and constants. Every Q value has F fraction bits. Magnitudes
    // are carried unsigned and the sign is applied at the end, which matches
    // the truncate-toward-zero rule of all products.
    // ------------------------------------------------------------------------
    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int W1  = W - 1;
    localparam int WP1 = W + 1;
    localparam int WP2 = W + 2;
    localparam int W2  = 2 * W;
    localparam int QW  = 2 * W - 2;      // product of two (W-1)-bit values
    localparam int RW  = 2 * W - 1;      // sum of two squares
    localparam int TW  = 2 * W + 1;      // square root trial value
    localparam int PW  = W + F;          // slip magnitude times stiffness
    localparam int SW  = W + F - 1;      // force magnitude times scale
    localparam int SRW = F + 2;          // slip ratio and slip angle
    localparam int MW  = F + 1;          // their magnitudes
    localparam int CW  = W + 3;          // CORDIC x and y
    localparam int AB  = ANG_BITS;
    localparam int NC  = CORDIC_STEPS;
    localparam int ASH = ANG_FRAC - F;
    localparam int LAT = 36 + W + F;

    localparam longint ONE_L   = longint'(1) << F;
    localparam longint EPS_L   = ((longint'(41943) << F) + (longint'(1) << 21)) >> 22;
    localparam longint NINE_L  = (9 * ONE_L + 5) / 10;
    localparam longint THREE_L = (3 * ONE_L + 5) / 10;

    localparam logic [W-1:0]          HALF_U   = W'(ONE_L >> 1);
    localparam logic signed [W-1:0]   ONE_S    = W'(ONE_L);
    localparam logic signed [W-1:0]   SMAX_S   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   NMAX_S   = -SMAX_S;
    localparam logic signed [W+1:0]   VMAX_S   = WP2'(SMAX_S);
    localparam logic signed [W+1:0]   VMIN_S   = -VMAX_S;
    localparam logic [W-2:0]          NINE_U   = W1'(NINE_L);
    localparam logic [MW-1:0]         ONE_M    = MW'(ONE_L);
    localparam logic [MW-1:0]         THREE_M  = MW'(THREE_L);
    localparam logic signed [SRW-1:0] ONE_SR   = SRW'(ONE_L);
    localparam logic signed [AB-1:0]  ONE_A    = AB'(ONE_L);
    localparam logic [W:0]            EPS_D    = WP1'(EPS_L);

    localparam logic [W-2:0] RST_GRIP  = W1'(ONE_L);
    localparam logic [W-2:0] RST_LONG  = W1'(20 * ONE_L);
    localparam logic [W-2:0] RST_LAT   = W1'(15 * ONE_L);
    localparam logic [W-2:0] RST_BRAKE = W1'(1000 * ONE_L);

    // Bundles carried alongside the iterative units.
    localparam int S3W = 4 + (W - 1) + QW + W + (W - 1);
    localparam int CBW = 2 * SRW + 2 * (W - 1) + 1;
    localparam int S6W = CBW + 2 * (W - 1);
    localparam int S8W = 2 * SRW + (W - 1) + 2 + 2 * (W - 1);

    // Drop F fraction bits of a product and saturate to the largest
    // positive word value.
    function automatic logic [W-2:0] sat_q(input logic [W2-1:0] p);
        logic [W2-1:0] s;
        s = p >> F;
        return (|s[W2-1:W-1]) ? '1 : s[W-2:0];
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index beyond the
    // register list is dropped.
    // ------------------------------------------------------------------------
    logic [W-2:0] grip_coef_reg;
    logic [W-2:0] long_stiff_reg;
    logic [W-2:0] lat_stiff_reg;
    logic [W-2:0] brake_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grip_coef_reg   <= RST_GRIP;
            long_stiff_reg  <= RST_LONG;
            lat_stiff_reg   <= RST_LAT;
            brake_limit_reg <= RST_BRAKE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GRIP:  grip_coef_reg   <= cfg_data;
                CFG_LONG:  long_stiff_reg  <= cfg_data;
                CFG_LAT:   lat_stiff_reg   <= cfg_data;
                CFG_BRAKE: brake_limit_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control. All stages move on the same enable, which is set
    // whenever the output register is empty or its word is being taken. A
    // shift register of valid bits follows the words through the stages.
    // ------------------------------------------------------------------------
    logic           ce;
    logic [LAT-1:0] vld_reg;

    assign ce       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = ce;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: operand conditioning and the three input products. The speed
    // floor replaces any vehicle speed below one half in magnitude by +0.5,
    // and the load is raised to at least 1.0.
    // ------------------------------------------------------------------------
    logic [W-1:0]        vmag_c;
    logic [W-1:0]        mvx_c;
    logic [W-1:0]        smag_c;
    logic signed [W-1:0] vx_c;
    logic signed [W-1:0] load_c;
    logic [W:0]          diff_c;
    logic [W:0]          mdiff_c;

    always_comb
    begin
        vmag_c = vehicle_speed[W-1] ? (~vehicle_speed) + W'(1) : vehicle_speed;
        if (vmag_c < HALF_U)
        begin
            vx_c  = HALF_U;
            mvx_c = HALF_U;
        end
        else
        begin
            vx_c  = vehicle_speed;
            mvx_c = vmag_c;
        end
        load_c  = (normal_load < ONE_S) ? ONE_S : normal_load;
        diff_c  = {wheel_speed[W-1], wheel_speed} - {vx_c[W-1], vx_c};
        mdiff_c = diff_c[W] ? (~diff_c) + WP1'(1) : diff_c;
        smag_c  = steer_angle[W-1] ? (~steer_angle) + W'(1) : steer_angle;
    end

    logic signed [W-1:0] s1_vx_reg;
    logic signed [W-1:0] s1_load_reg;
    logic [W:0]          s1_mdiff_reg;
    logic [W-1:0]        s1_mvx_reg;
    logic                s1_big_reg;
    logic                s1_srneg_reg;
    logic [W2-1:0]       s1_svp_reg;
    logic                s1_svneg_reg;
    logic signed [W-1:0] s1_lat_reg;
    logic [QW-1:0]       s1_gp_reg;
    logic signed [W-1:0] s1_brake_reg;
    logic [QW-1:0]       s1_thp_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_vx_reg    <= vx_c;
            s1_load_reg  <= load_c;
            s1_mdiff_reg <= mdiff_c;
            s1_mvx_reg   <= mvx_c;
            s1_big_reg   <= mdiff_c >= WP1'(mvx_c);
            s1_srneg_reg <= diff_c[W] != vx_c[W-1];
            s1_svp_reg   <= W2'(smag_c) * W2'(mvx_c);
            s1_svneg_reg <= steer_angle[W-1] != vx_c[W-1];
            s1_lat_reg   <= lateral_velocity;
            s1_gp_reg    <= QW'(grip_coef_reg) * QW'(surface_grip);
            s1_brake_reg <= brake_torque;
            s1_thp_reg   <= QW'(brake_limit_reg) * QW'(NINE_U);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: saturate the products, form the lateral term, and start the
    // friction limit product grip * load.
    // ------------------------------------------------------------------------
    logic [W-2:0]        svmag_c;
    logic signed [W+1:0] svs_c;
    logic signed [W+1:0] vyw_c;
    logic signed [W-1:0] vy_c;
    logic [W-2:0]        grip_c;
    logic [W-2:0]        thr_c;

    always_comb
    begin
        svmag_c = sat_q(s1_svp_reg);
        svs_c   = {3'b000, svmag_c};
        if (s1_svneg_reg)
        begin
            svs_c = -svs_c;
        end
        vyw_c = {{2{s1_lat_reg[W-1]}}, s1_lat_reg} - svs_c;
        if (vyw_c > VMAX_S)
        begin
            vy_c = SMAX_S;
        end
        else if (vyw_c < VMIN_S)
        begin
            vy_c = NMAX_S;
        end
        else
        begin
            vy_c = W'(vyw_c);
        end
        grip_c = sat_q(W2'(s1_gp_reg));
        thr_c  = sat_q(W2'(s1_thp_reg));
    end

    logic signed [W-1:0] s2_vx_reg;
    logic signed [W-1:0] s2_vy_reg;
    logic [W-2:0]        s2_grip_reg;
    logic [W-2:0]        s2_thr_reg;
    logic [QW-1:0]       s2_mfp_reg;
    logic signed [W-1:0] s2_brake_reg;
    logic [W:0]          s2_mdiff_reg;
    logic [W-1:0]        s2_mvx_reg;
    logic                s2_big_reg;
    logic                s2_srneg_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s2_vx_reg    <= s1_vx_reg;
            s2_vy_reg    <= vy_c;
            s2_grip_reg  <= grip_c;
            s2_thr_reg   <= thr_c;
            s2_mfp_reg   <= QW'(grip_c) * QW'(s1_load_reg[W-2:0]);
            s2_brake_reg <= s1_brake_reg;
            s2_mdiff_reg <= s1_mdiff_reg;
            s2_mvx_reg   <= s1_mvx_reg;
            s2_big_reg   <= s1_big_reg;
            s2_srneg_reg <= s1_srneg_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stages 3 to 27: one CORDIC vectoring step per stage for the slip angle,
    // and in the first F of them one restoring division step per stage for
    // the slip ratio |wheel - vx| / |vx|.
    // ------------------------------------------------------------------------
    logic signed [CW-1:0] cx_reg [NC];
    logic signed [CW-1:0] cy_reg [NC];
    logic signed [AB-1:0] cz_reg [NC];
    logic [F-1:0]         dq_reg [NC];
    logic [W:0]           dr_reg [NC];
    logic [W-1:0]         dd_reg [NC];
    logic [S3W-1:0]       s3_reg [NC];

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        logic signed [CW-1:0] xi;
        logic signed [CW-1:0] yi;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [AB-1:0] zi;
        logic [F-1:0]         qi;
        logic [W:0]           ri;
        logic [W-1:0]         di;
        logic [S3W-1:0]       si;
        logic [W+1:0]         r2;
        logic                 ge;

        if (i == 0)
        begin : g_first
            assign xi = CW'(s2_vx_reg);
            assign yi = CW'(s2_vy_reg);
            assign zi = '0;
            assign qi = '0;
            assign ri = s2_mdiff_reg;
            assign di = s2_mvx_reg;
            assign si = {s2_srneg_reg, s2_big_reg, s2_vx_reg[W-1], s2_vy_reg[W-1],
                         s2_grip_reg, s2_mfp_reg, s2_brake_reg, s2_thr_reg};
        end
        else
        begin : g_next
            assign xi = cx_reg[i-1];
            assign yi = cy_reg[i-1];
            assign zi = cz_reg[i-1];
            assign qi = dq_reg[i-1];
            assign ri = dr_reg[i-1];
            assign di = dd_reg[i-1];
            assign si = s3_reg[i-1];
        end

        assign xs = xi >>> i;
        assign ys = yi >>> i;
        assign r2 = {ri, 1'b0};
        assign ge = r2 >= WP2'(di);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (yi > 0)
                begin
                    cx_reg[i] <= xi + ys;
                    cy_reg[i] <= yi - xs;
                    cz_reg[i] <= zi + $signed(atan_q24(i));
                end
                else
                begin
                    cx_reg[i] <= xi - ys;
                    cy_reg[i] <= yi + xs;
                    cz_reg[i] <= zi - $signed(atan_q24(i));
                end
                if (i < F)
                begin
                    dr_reg[i] <= ge ? WP1'(r2 - WP2'(di)) : WP1'(r2);
                    dq_reg[i] <= {qi[F-2:0], ge};
                end
                else
                begin
                    dr_reg[i] <= ri;
                    dq_reg[i] <= qi;
                end
                dd_reg[i] <= di;
                s3_reg[i] <= si;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 28: finish both slips. When reversing the angle is pinned to
    // plus or minus one by the sign of the lateral term. The lock flag is
    // decided here too.
    // ------------------------------------------------------------------------
    logic                 u3_srneg;
    logic                 u3_big;
    logic                 u3_vxneg;
    logic                 u3_vyneg;
    logic [W-2:0]         u3_grip;
    logic [QW-1:0]        u3_mfp;
    logic signed [W-1:0]  u3_brake;
    logic [W-2:0]         u3_thr;
    logic signed [AB-1:0] zr_c;
    logic signed [AB-1:0] zcl_c;
    logic signed [SRW-1:0] sa_c;
    logic signed [SRW-1:0] sr_c;
    logic [MW-1:0]        msr_c;
    logic [MW-1:0]        msa_c;

    assign {u3_srneg, u3_big, u3_vxneg, u3_vyneg, u3_grip, u3_mfp, u3_brake, u3_thr} =
        s3_reg[NC-1];

    if (ASH > 0)
    begin : g_round
        localparam logic signed [AB-1:0] ZRND = AB'(longint'(1) << (ASH - 1));
        logic signed [AB-1:0] zsum;
        assign zsum = cz_reg[NC-1] + ZRND;
        assign zr_c = zsum >>> ASH;
    end
    else
    begin : g_noround
        assign zr_c = cz_reg[NC-1];
    end

    always_comb
    begin
        if (zr_c > ONE_A)
        begin
            zcl_c = ONE_A;
        end
        else if (zr_c < -ONE_A)
        begin
            zcl_c = -ONE_A;
        end
        else
        begin
            zcl_c = zr_c;
        end
        if (u3_vxneg)
        begin
            sa_c = u3_vyneg ? -ONE_SR : ONE_SR;
        end
        else
        begin
            sa_c = SRW'(zcl_c);
        end
        msa_c = sa_c[SRW-1] ? MW'(-sa_c) : MW'(sa_c);
        msr_c = u3_big ? ONE_M : MW'(dq_reg[NC-1]);
        sr_c  = u3_srneg ? -SRW'(msr_c) : SRW'(msr_c);
    end

    logic signed [SRW-1:0] s4_sr_reg;
    logic signed [SRW-1:0] s4_sa_reg;
    logic [MW-1:0]         s4_msr_reg;
    logic [MW-1:0]         s4_msa_reg;
    logic [W-2:0]          s4_grip_reg;
    logic [W-2:0]          s4_maxf_reg;
    logic                  s4_lock_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s4_sr_reg   <= sr_c;
            s4_sa_reg   <= sa_c;
            s4_msr_reg  <= msr_c;
            s4_msa_reg  <= msa_c;
            s4_grip_reg <= u3_grip;
            s4_maxf_reg <= sat_q(W2'(u3_mfp));
            s4_lock_reg <= (u3_brake > $signed({1'b0, u3_thr})) && (msr_c > THREE_M);
        end
    end

    // ------------------------------------------------------------------------
    // Stages 29 to 33: linear forces slip * stiffness * grip, then their
    // squares and the sum of squares for the force vector length.
    // ------------------------------------------------------------------------
    logic [CBW-1:0] cb_c;
    logic [PW-1:0]  f1_pl_reg;
    logic [PW-1:0]  f1_pa_reg;
    logic [CBW-1:0] f1_cb_reg;
    logic [QW-1:0]  f2_ql_reg;
    logic [QW-1:0]  f2_qa_reg;
    logic [CBW-1:0] f2_cb_reg;
    logic [W-2:0]   f3_ml_reg;
    logic [W-2:0]   f3_ma_reg;
    logic [CBW-1:0] f3_cb_reg;
    logic [QW-1:0]  f4_sql_reg;
    logic [QW-1:0]  f4_sqa_reg;
    logic [W-2:0]   f4_ml_reg;
    logic [W-2:0]   f4_ma_reg;
    logic [CBW-1:0] f4_cb_reg;
    logic [RW-1:0]  f5_sum_reg;
    logic [W-2:0]   f5_ml_reg;
    logic [W-2:0]   f5_ma_reg;
    logic [CBW-1:0] f5_cb_reg;
    logic [W-2:0]   u1_grip;

    assign cb_c = {s4_sr_reg, s4_sa_reg, s4_grip_reg, s4_maxf_reg, s4_lock_reg};
    assign u1_grip = f1_cb_reg[2*(W-1):W];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            f1_pl_reg  <= PW'(s4_msr_reg) * PW'(long_stiff_reg);
            f1_pa_reg  <= PW'(s4_msa_reg) * PW'(lat_stiff_reg);
            f1_cb_reg  <= cb_c;
            f2_ql_reg  <= QW'(sat_q(W2'(f1_pl_reg))) * QW'(u1_grip);
            f2_qa_reg  <= QW'(sat_q(W2'(f1_pa_reg))) * QW'(u1_grip);
            f2_cb_reg  <= f1_cb_reg;
            f3_ml_reg  <= sat_q(W2'(f2_ql_reg));
            f3_ma_reg  <= sat_q(W2'(f2_qa_reg));
            f3_cb_reg  <= f2_cb_reg;
            f4_sql_reg <= QW'(f3_ml_reg) * QW'(f3_ml_reg);
            f4_sqa_reg <= QW'(f3_ma_reg) * QW'(f3_ma_reg);
            f4_ml_reg  <= f3_ml_reg;
            f4_ma_reg  <= f3_ma_reg;
            f4_cb_reg  <= f3_cb_reg;
            f5_sum_reg <= RW'(f4_sql_reg) + RW'(f4_sqa_reg);
            f5_ml_reg  <= f4_ml_reg;
            f5_ma_reg  <= f4_ma_reg;
            f5_cb_reg  <= f4_cb_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Next W stages: integer square root, one result bit per stage from the
    // top. The remainder keeps sum - root^2 so each step is one compare and
    // subtract.
    // ------------------------------------------------------------------------
    logic [RW-1:0]  qrem_reg  [W];
    logic [W-1:0]   qroot_reg [W];
    logic [S6W-1:0] s6_reg    [W];

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        localparam int B = W - 1 - k;
        logic [RW-1:0]  remi;
        logic [W-1:0]   rooti;
        logic [S6W-1:0] si;
        logic [TW-1:0]  trial;
        logic           fit;

        if (k == 0)
        begin : g_first
            assign remi  = f5_sum_reg;
            assign rooti = '0;
            assign si    = {f5_cb_reg, f5_ml_reg, f5_ma_reg};
        end
        else
        begin : g_next
            assign remi  = qrem_reg[k-1];
            assign rooti = qroot_reg[k-1];
            assign si    = s6_reg[k-1];
        end

        assign trial = (TW'(rooti) << (B + 1)) + (TW'(1) << (2 * B));
        assign fit   = trial <= TW'(remi);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                qrem_reg[k]  <= fit ? RW'(TW'(remi) - trial) : remi;
                qroot_reg[k] <= rooti | (fit ? (W'(1) << B) : '0);
                s6_reg[k]    <= si;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Friction circle test. The forces are scaled only when the length is
    // strictly above grip * load; the divisor gets a small epsilon.
    // ------------------------------------------------------------------------
    logic signed [SRW-1:0] u6_sr;
    logic signed [SRW-1:0] u6_sa;
    logic [W-2:0]          u6_grip;
    logic [W-2:0]          u6_maxf;
    logic                  u6_lock;
    logic [W-2:0]          u6_ml;
    logic [W-2:0]          u6_ma;
    logic [W-1:0]          total_c;

    assign {u6_sr, u6_sa, u6_grip, u6_maxf, u6_lock, u6_ml, u6_ma} = s6_reg[W-1];
    assign total_c = qroot_reg[W-1];

    logic [W:0]     s7_r_reg;
    logic [W:0]     s7_d_reg;
    logic [S8W-1:0] s7_bus_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s7_r_reg   <= WP1'(u6_maxf);
            s7_d_reg   <= WP1'(total_c) + EPS_D;
            s7_bus_reg <= {u6_sr, u6_sa, u6_grip, u6_lock, total_c > W'(u6_maxf),
                           u6_ml, u6_ma};
        end
    end

    // Next F stages: scale = max / (length + eps), one quotient bit each.
    logic [W:0]     er_reg [F];
    logic [W:0]     ed_reg [F];
    logic [F-1:0]   eq_reg [F];
    logic [S8W-1:0] s8_reg [F];

    for (genvar j = 0; j < F; j++)
    begin : g_scale
        logic [W:0]     ri;
        logic [W:0]     di;
        logic [F-1:0]   qi;
        logic [S8W-1:0] si;
        logic [W+1:0]   r2;
        logic           ge;

        if (j == 0)
        begin : g_first
            assign ri = s7_r_reg;
            assign di = s7_d_reg;
            assign qi = '0;
            assign si = s7_bus_reg;
        end
        else
        begin : g_next
            assign ri = er_reg[j-1];
            assign di = ed_reg[j-1];
            assign qi = eq_reg[j-1];
            assign si = s8_reg[j-1];
        end

        assign r2 = {ri, 1'b0};
        assign ge = r2 >= WP2'(di);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                er_reg[j] <= ge ? WP1'(r2 - WP2'(di)) : WP1'(r2);
                ed_reg[j] <= di;
                eq_reg[j] <= {qi[F-2:0], ge};
                s8_reg[j] <= si;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Last two stages: scale the force magnitudes, then choose, sign and
    // register the output word.
    // ------------------------------------------------------------------------
    logic [SW-1:0]  s9_pl_reg;
    logic [SW-1:0]  s9_pa_reg;
    logic [S8W-1:0] s9_bus_reg;
    logic [W-2:0]   u8_ml;
    logic [W-2:0]   u8_ma;

    assign u8_ml = s8_reg[F-1][2*(W-1)-1:W-1];
    assign u8_ma = s8_reg[F-1][W-2:0];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s9_pl_reg  <= SW'(u8_ml) * SW'(eq_reg[F-1]);
            s9_pa_reg  <= SW'(u8_ma) * SW'(eq_reg[F-1]);
            s9_bus_reg <= s8_reg[F-1];
        end
    end

    logic signed [SRW-1:0] u9_sr;
    logic signed [SRW-1:0] u9_sa;
    logic [W-2:0]          u9_grip;
    logic                  u9_lock;
    logic                  u9_slip;
    logic [W-2:0]          u9_ml;
    logic [W-2:0]          u9_ma;
    logic [W-2:0]          lfm_c;
    logic [W-2:0]          afm_c;

    assign {u9_sr, u9_sa, u9_grip, u9_lock, u9_slip, u9_ml, u9_ma} = s9_bus_reg;
    assign lfm_c = u9_slip ? sat_q(W2'(s9_pl_reg)) : u9_ml;
    assign afm_c = u9_slip ? sat_q(W2'(s9_pa_reg)) : u9_ma;

    logic signed [SRW-1:0] out_sr_reg;
    logic signed [SRW-1:0] out_sa_reg;
    logic signed [W-1:0]   out_lf_reg;
    logic signed [W-1:0]   out_af_reg;
    logic [W-2:0]          out_grip_reg;
    logic                  out_slip_reg;
    logic                  out_lock_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_sr_reg   <= u9_sr;
            out_sa_reg   <= u9_sa;
            out_lf_reg   <= u9_sr[SRW-1] ? -W'(lfm_c) : W'(lfm_c);
            out_af_reg   <= u9_sa[SRW-1] ? -W'(afm_c) : W'(afm_c);
            out_grip_reg <= u9_grip;
            out_slip_reg <= u9_slip;
            out_lock_reg <= u9_lock;
        end
    end

    assign slip_ratio = out_sr_reg;
    assign slip_angle = out_sa_reg;
    assign long_force = out_lf_reg;
    assign lat_force  = out_af_reg;
    assign grip_used  = out_grip_reg;
    assign slipping   = out_slip_reg;
    assign locked     = out_lock_reg;

`ifndef NO_ASSERTIONS
    a_slip_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (slip_ratio <= ONE_SR && slip_ratio >= -ONE_SR))
        else $error("slip ratio outside [-1, 1]");

    a_slip_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (slip_angle <= ONE_SR && slip_angle >= -ONE_SR))
        else $error("slip angle outside [-1, 1]");

    a_lock_needs_slip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && locked) |->
            (slip_ratio > $signed(SRW'(THREE_M)) || slip_ratio < -$signed(SRW'(THREE_M))))
        else $error("lock flag without enough slip");

    a_zero_slip_no_force: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && slip_ratio == '0) |-> (long_force == '0))
        else $error("longitudinal force without slip");
`endif

endmodule

`default_nettype wire

>>> tb/tsff_checker.sv
// ============================================================================
// Tire slip friction force checker
// Watches the configuration, input and output channels, predicts each result
// word from the accepted input word and the current register settings, and
// compares all output fields of each word together, in order.
// ============================================================================
`timescale 1ns / 1ps

module tsff_checker
    import tsff_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [30:0]         cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic signed [31:0]  wheel_speed,
    input  logic signed [31:0]  vehicle_speed,
    input  logic signed [31:0]  lateral_velocity,
    input  logic signed [31:0]  normal_load,
    input  logic signed [31:0]  brake_torque,
    input  logic [30:0]         surface_grip,
    input  logic signed [31:0]  steer_angle,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic signed [17:0]  slip_ratio,
    input  logic signed [17:0]  slip_angle,
    input  logic signed [31:0]  long_force,
    input  logic signed [31:0]  lat_force,
    input  logic [30:0]         grip_used,
    input  logic                slipping,
    input  logic                locked,
    output int                  fail_count,
    output int                  pending
);

    localparam longint ONE_Q = 64'sd65536;
    localparam longint SMAX  = 64'sd2147483647;
    localparam longint EPS_Q = 64'sd655;
    localparam longint NINE_TENTHS  = 64'sd58982;
    localparam longint THREE_TENTHS = 64'sd19661;

    typedef struct packed {
        logic signed [17:0] sr;
        logic signed [17:0] sa;
        logic signed [31:0] lf;
        logic signed [31:0] af;
        logic [30:0]        grip;
        logic               slip;
        logic               lock;
    } tire_result_t;

    tire_result_t expected_words[$];
    logic [30:0] grip_coef, long_stiff, lat_stiff, brake_limit;

    // Unsigned Q product, truncated, saturated at the top of the signed word.
    function automatic longint qmul_mag(longint a, longint b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        p = p >> 16;
        return (p > 128'(SMAX)) ? SMAX : longint'(p[63:0]);
    endfunction

    function automatic longint qmul_signed(longint a, longint b);
        longint m;
        m = qmul_mag(a < 0 ? -a : a, b < 0 ? -b : b);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // Quotient n/d in Q16, valid for n < d.
    function automatic longint qdiv_frac(longint n, longint d);
        return (n <<< 16) / d;
    endfunction

    function automatic longint isqrt128(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n) r = c;
        end
        return longint'(r);
    endfunction

    function automatic longint atan_vectoring(longint x, longint y);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += longint'(atan_q24(i));
            end
            else begin
                x -= ys; y += xs; z -= longint'(atan_q24(i));
            end
        end
        return (z + 128) >>> 8;
    endfunction

    function automatic tire_result_t predict_tire(longint wheel, longint vx, longint latv,
            longint load, longint brake, longint surf, longint steer);
        tire_result_t r;
        longint diff, m, sr, sa, vy, grip, lf, af, maxf, total, scale, lim;
        logic [127:0] sq;
        r = '0;
        if (load < ONE_Q) load = ONE_Q;
        if ((vx < 0 ? -vx : vx) < ONE_Q / 2) vx = ONE_Q / 2;
        diff = wheel - vx;
        m = ((diff < 0 ? -diff : diff) >= (vx < 0 ? -vx : vx)) ? ONE_Q
            : qdiv_frac(diff < 0 ? -diff : diff, vx < 0 ? -vx : vx);
        sr = ((diff < 0) != (vx < 0)) ? -m : m;
        vy = latv - qmul_signed(steer, vx);
        if (vy > SMAX) vy = SMAX;
        if (vy < -SMAX) vy = -SMAX;
        if (vx < 0) sa = (vy < 0) ? -ONE_Q : ONE_Q;
        else begin
            sa = atan_vectoring(vx, vy);
            if (sa > ONE_Q) sa = ONE_Q;
            if (sa < -ONE_Q) sa = -ONE_Q;
        end
        grip = qmul_mag(longint'(grip_coef), surf);
        lf = qmul_signed(qmul_signed(sr, longint'(long_stiff)), grip);
        af = qmul_signed(qmul_signed(sa, longint'(lat_stiff)), grip);
        maxf = qmul_mag(grip, load);
        sq = 128'(lf < 0 ? -lf : lf) * 128'(lf < 0 ? -lf : lf)
           + 128'(af < 0 ? -af : af) * 128'(af < 0 ? -af : af);
        total = isqrt128(sq);
        if (total > maxf) begin
            scale = qdiv_frac(maxf, total + EPS_Q);
            lf = (lf < 0) ? -qmul_mag(-lf, scale) : qmul_mag(lf, scale);
            af = (af < 0) ? -qmul_mag(-af, scale) : qmul_mag(af, scale);
            r.slip = 1'b1;
        end
        lim = qmul_mag(longint'(brake_limit), NINE_TENTHS);
        r.lock = (brake > lim) && ((sr < 0 ? -sr : sr) > THREE_TENTHS);
        r.sr = sr[17:0];
        r.sa = sa[17:0];
        r.lf = lf[31:0];
        r.af = af[31:0];
        r.grip = grip[30:0];
        return r;
    endfunction

    assign pending = expected_words.size();

    always @(posedge clk or negedge rst_n) begin
        tire_result_t want;
        if (!rst_n) begin
            grip_coef   <= 31'd65536;
            long_stiff  <= 31'd1310720;
            lat_stiff   <= 31'd983040;
            brake_limit <= 31'd65536000;
            fail_count  <= 0;
            expected_words.delete();
        end
        else begin
            if (in_valid && in_ready)
                expected_words.push_back(predict_tire(wheel_speed, vehicle_speed,
                    lateral_velocity, normal_load, brake_torque,
                    longint'(surface_grip), steer_angle));
            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected output word", $time);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_words.pop_front();
                    if (want !== {slip_ratio, slip_angle, long_force, lat_force,
                                  grip_used, slipping, locked}) begin
                        $display("%0t: mismatch expected sr=%0d sa=%0d lf=%0d af=%0d g=%0d s=%0b l=%0b",
                            $time, want.sr, want.sa, want.lf, want.af, want.grip,
                            want.slip, want.lock);
                        $display("%0t:          actual   sr=%0d sa=%0d lf=%0d af=%0d g=%0d s=%0b l=%0b",
                            $time, slip_ratio, slip_angle, long_force, lat_force,
                            grip_used, slipping, locked);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GRIP:  grip_coef   <= cfg_data;
                    CFG_LONG:  long_stiff  <= cfg_data;
                    CFG_LAT:   lat_stiff   <= cfg_data;
                    CFG_BRAKE: brake_limit <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> tb/tb.sv
// ============================================================================
// Tire slip friction force testbench
// Drives directed and random tire words through several register settings
// with random idling on both sides; the checker predicts and compares.
// ============================================================================
`timescale 1ns / 1ps

module tb
    import tsff_pkg::*;
();

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [30:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] wheel_speed = '0, vehicle_speed = '0, lateral_velocity = '0;
    logic signed [31:0] normal_load = '0, brake_torque = '0, steer_angle = '0;
    logic [30:0] surface_grip = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [17:0] slip_ratio, slip_angle;
    logic signed [31:0] long_force, lat_force;
    logic [30:0] grip_used;
    logic slipping, locked;
    int fail_count;
    int pending;
    // When set, neither side idles; used for one long stretch.
    bit steady = 1'b0;

    always #5 clk = ~clk;

    tire_slip_friction_force dut (.*);
    tsff_checker chk (.*);

    // The receiver stalls at random, with a chance of 38 in 100, unless in a steady stretch.
    always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 38);

    // Random Q value: mostly modest physical magnitudes, sometimes any pattern.
    function automatic logic [31:0] rand_q(int unsigned span);
        case ($urandom_range(3))
            0:       return $urandom;
            default: return 32'($signed($urandom_range(2 * span)) - $signed(span));
        endcase
    endfunction

    // Valid stays high after the accepting edge; the next idle cycle or the
    // caller drops it, and a next word keeps it high with new data.
    task automatic send_word(logic [31:0] w, v, l, n, b, logic [30:0] g, logic [31:0] s);
        while (!steady && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        wheel_speed <= w; vehicle_speed <= v; lateral_velocity <= l;
        normal_load <= n; brake_torque <= b; surface_grip <= g; steer_angle <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random();
        logic [31:0] v;
        v = rand_q(32'd3000000);
        send_word(v + rand_q(32'd600000), v, rand_q(32'd400000), rand_q(32'd60000000),
                  rand_q(32'd70000000), ($urandom_range(3) == 0) ? 31'($urandom)
                  : 31'($urandom_range(131072)), rand_q(32'd40000));
    endtask

    // Drain everything outstanding, then let the pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, slow and reversing vehicle, lock, slip limit.
        send_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 31'h0, 32'h80000000);
        send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 31'h7fffffff, 32'h7fffffff);
        send_word(32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 31'd65536, 32'd0);
        send_word(32'd0, 32'hffff8000, 32'd1000, 32'd100000, 32'd0, 31'd65536, 32'd0);
        send_word(32'd0, 32'hffff8001, 32'd1000, 32'd100000, 32'd0, 31'd65536, 32'd0);
        send_word(32'd0, -32'd655360, 32'd5000, 32'd100000, 32'd0, 31'd65536, 32'd0);
        send_word(32'd0, -32'd655360, -32'd5000, 32'd100000, 32'd0, 31'd65536, 32'd0);
        send_word(32'd0, 32'd655360, 32'd0, 32'd65536000, 32'd65536000, 31'd65536, 32'd0);
        send_word(32'd0, 32'd655360, 32'd0, 32'd65536000, 32'd58982400, 31'd65536, 32'd0);
        send_word(32'd1310720, 32'd655360, 32'd655360, 32'd65536, 32'd0, 31'd65536, 32'd6553);
        send_word(32'd655360, 32'd655360, 32'd0, 32'd65536, 32'd0, 31'd65536, 32'd0);
        send_word(32'd458752, 32'd655360, 32'h7fffffff, 32'd65536, 32'd0, 31'd131072,
                  32'h80000000);
        wait_idle();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_GRIP, 31'h7fffffff);
                    write_reg(CFG_LONG, 31'h7fffffff);
                    write_reg(CFG_LAT, 31'h7fffffff);
                    write_reg(CFG_BRAKE, 31'h7fffffff);
                end
                1: begin
                    write_reg(CFG_GRIP, 31'd0);
                    write_reg(CFG_LONG, 31'd0);
                    write_reg(CFG_LAT, 31'd0);
                    write_reg(CFG_BRAKE, 31'd0);
                end
                2: begin
                    write_reg(CFG_GRIP, 31'd65536);
                    write_reg(CFG_LONG, 31'd1310720);
                    write_reg(CFG_LAT, 31'd983040);
                    write_reg(CFG_BRAKE, 31'd65536000);
                    // An index past the list must be ignored.
                    write_reg(cfg_index_t'(3'd5), 31'd12345);
                end
                default: begin
                    write_reg(CFG_GRIP, 31'($urandom_range(200000)));
                    write_reg(CFG_LONG, 31'($urandom));
                    write_reg(CFG_LAT, 31'($urandom_range(3000000)));
                    write_reg(CFG_BRAKE, 31'($urandom_range(90000000)));
                end
            endcase
            cfg_valid <= 1'b0;
            steady = (phase == 2);
            for (int k = 0; k < 140; k++) begin
                send_random();
                if (phase == 3 && k == 70) wait_idle();
            end
            steady = 1'b0;
            wait_idle();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
